/* hw/rtl/aimsteer_pkg.sv */
// ----------------------------------------------------------------------------
// aimsteer_pkg
// Shared types and constants for the two-axis bang-bang aim steering block.
// ----------------------------------------------------------------------------
package aimsteer_pkg;

  // Fixed field widths
  localparam int ANGLE_IN_BITS = 15;
  localparam int ERR_BITS      = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Angles in 1/64 degree
  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;

  // Key held on an axis
  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_POS  = 2'd1,
    KEY_NEG  = 2'd2
  } key_t;

  // Direction calibration codes (signed)
  localparam logic signed [1:0] DIR_UNKNOWN = 2'sb00;
  localparam logic signed [1:0] DIR_POS     = 2'sb01;
  localparam logic signed [1:0] DIR_NEG     = 2'sb11;

  localparam logic [2:0] AGREE_MAX = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HYSTERESIS    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWING_HOLD    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_GRACE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_MIN     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIB_LOCK    = 3'd5;

  // Configuration reset values
  localparam logic [13:0] DEADBAND_RST      = 14'd192;
  localparam logic [13:0] HYSTERESIS_RST    = 14'd128;
  localparam logic [15:0] SWING_HOLD_RST    = 16'd350;
  localparam logic [15:0] RELEASE_GRACE_RST = 16'd250;
  localparam logic [13:0] CALIB_MIN_RST     = 14'd32;
  localparam logic [2:0]  CALIB_LOCK_RST    = 3'd2;

  typedef struct packed {
    logic [13:0] deadband;
    logic [13:0] hysteresis_margin;
    logic [15:0] swing_hold_ms;
    logic [15:0] release_grace_ms;
    logic [13:0] calib_min_delta;
    logic [2:0]  calib_lock_samples;
  } cfg_t;

  // Per-axis control flags for one tick
  typedef struct packed {
    logic engaged;
    logic full_auto;
    logic wraps;
    logic pos_down;
    logic neg_down;
  } axis_ctl_t;

endpackage

/* hw/rtl/aimsteer_axis.sv */
// ----------------------------------------------------------------------------
// aimsteer_axis
// One axis: bang-bang drive with deadband and hysteresis, key direction
// calibration from observed motion, and manual-hold yield latch.
// ----------------------------------------------------------------------------
module aimsteer_axis #(
  parameter int ANGLE_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       step,
  input  aimsteer_pkg::axis_ctl_t                    ctl,
  input  aimsteer_pkg::cfg_t                         cfg,
  input  logic signed [aimsteer_pkg::ANGLE_IN_BITS-1:0] cur,
  input  logic signed [aimsteer_pkg::ANGLE_IN_BITS-1:0] tgt,
  input  logic [TIME_BITS-1:0]                       now,
  output logic [1:0]                                 key,
  output logic signed [1:0]                          direction,
  output logic                                       yielding
);

  localparam int DW = ANGLE_BITS + 2;
  localparam int EW = aimsteer_pkg::ERR_BITS;

  localparam logic signed [DW-1:0] HALF_D = DW'(aimsteer_pkg::HALF_TURN);
  localparam logic signed [DW-1:0] FULL_D = DW'(aimsteer_pkg::FULL_TURN);
  localparam logic signed [EW-1:0] HALF_E = EW'(aimsteer_pkg::HALF_TURN);
  localparam logic signed [EW-1:0] FULL_E = EW'(aimsteer_pkg::FULL_TURN);

  // State
  aimsteer_pkg::key_t           held_key;
  aimsteer_pkg::key_t           last_tick_key;
  logic signed [1:0]            direction_lock;
  logic signed [1:0]            direction_guess;
  logic [2:0]                   agree_count;
  logic signed [ANGLE_BITS-1:0] previous_coord;
  logic                         previous_valid;
  logic                         player_was_active;
  logic [TIME_BITS-1:0]         hold_start_time;
  logic [TIME_BITS-1:0]         last_manual_time;
  logic                         swing_latch;

  // Next values
  aimsteer_pkg::key_t   held_key_next;
  logic signed [1:0]    direction_lock_next;
  logic signed [1:0]    direction_guess_next;
  logic [2:0]           agree_count_next;
  logic [TIME_BITS-1:0] hold_start_time_next;
  logic [TIME_BITS-1:0] last_manual_time_next;
  logic                 swing_latch_next;

  logic signed [EW-1:0] err_raw, err;
  logic [EW-1:0]        err_mag;
  logic signed [DW-1:0] delta_raw, delta;
  logic [DW-1:0]        delta_mag;
  logic                 cal_en, dsign_neg, psign_neg;
  logic signed [1:0]    psign;
  logic                 active;
  logic [TIME_BITS-1:0] hold_age, quiet_age;
  logic                 inc_is_pos;
  logic                 want_inc, want_dec;

  // Tracking error, azimuth wraps into one half turn either side
  always_comb begin
    err_raw = EW'(cur) - EW'(tgt);
    err     = err_raw;
    if (ctl.wraps && err_raw > HALF_E) begin
      err = err_raw - FULL_E;
    end else if (ctl.wraps && err_raw < -HALF_E) begin
      err = err_raw + FULL_E;
    end
    err_mag = err[EW-1] ? EW'(-err) : EW'(err);
  end

  // Calibration from motion seen since the last tick
  always_comb begin
    delta_raw = DW'(cur) - DW'(previous_coord);
    delta     = delta_raw;
    if (ctl.wraps && delta_raw > HALF_D) begin
      delta = delta_raw - FULL_D;
    end else if (ctl.wraps && delta_raw < -HALF_D) begin
      delta = delta_raw + FULL_D;
    end
    delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);

    cal_en = (direction_lock == aimsteer_pkg::DIR_UNKNOWN) && previous_valid &&
             (last_tick_key == aimsteer_pkg::KEY_POS ||
              last_tick_key == aimsteer_pkg::KEY_NEG) &&
             (delta_mag >= DW'(cfg.calib_min_delta));
    dsign_neg = !(delta > 0);
    psign_neg = (last_tick_key == aimsteer_pkg::KEY_POS) ? dsign_neg : !dsign_neg;
    psign     = psign_neg ? aimsteer_pkg::DIR_NEG : aimsteer_pkg::DIR_POS;

    direction_guess_next = direction_guess;
    agree_count_next     = agree_count;
    direction_lock_next  = direction_lock;
    if (cal_en) begin
      direction_guess_next = psign;
      if (agree_count == 3'd0 || psign == direction_guess) begin
        agree_count_next = (agree_count == aimsteer_pkg::AGREE_MAX) ?
                           aimsteer_pkg::AGREE_MAX : agree_count + 3'd1;
      end else begin
        agree_count_next = 3'd1;
      end
      if (agree_count_next >= cfg.calib_lock_samples) begin
        direction_lock_next = psign;
      end
    end
  end

  // Manual hold detection and yield latch
  always_comb begin
    active = (ctl.pos_down && held_key != aimsteer_pkg::KEY_POS) ||
             (ctl.neg_down && held_key != aimsteer_pkg::KEY_NEG);
    hold_start_time_next  = (active && !player_was_active) ? now : hold_start_time;
    last_manual_time_next = last_manual_time;
    swing_latch_next      = swing_latch;
    hold_age  = now - hold_start_time_next;
    quiet_age = now - last_manual_time;
    if (active) begin
      last_manual_time_next = now;
      if (hold_age >= TIME_BITS'(cfg.swing_hold_ms)) begin
        swing_latch_next = 1'b1;
      end
    end else if (swing_latch && quiet_age >= TIME_BITS'(cfg.release_grace_ms)) begin
      swing_latch_next = 1'b0;
    end
  end

  // Bang-bang drive with hysteresis from idle
  always_comb begin
    inc_is_pos = (direction_lock_next != aimsteer_pkg::DIR_NEG);
    want_inc   = err < -$signed(EW'(cfg.deadband));
    want_dec   = err > $signed(EW'(cfg.deadband));
    if (held_key == aimsteer_pkg::KEY_NONE &&
        err_mag < (EW'(cfg.deadband) + EW'(cfg.hysteresis_margin))) begin
      want_inc = 1'b0;
      want_dec = 1'b0;
    end
    if (!ctl.full_auto && swing_latch_next) begin
      held_key_next = aimsteer_pkg::KEY_NONE;
    end else if (want_inc) begin
      held_key_next = inc_is_pos ? aimsteer_pkg::KEY_POS : aimsteer_pkg::KEY_NEG;
    end else if (want_dec) begin
      held_key_next = inc_is_pos ? aimsteer_pkg::KEY_NEG : aimsteer_pkg::KEY_POS;
    end else begin
      held_key_next = aimsteer_pkg::KEY_NONE;
    end
  end

  // Update state once per transfer; disengaged ticks release the keys and record the player's key state only
  always_ff @(posedge clk) begin
    if (rst) begin
      held_key          <= aimsteer_pkg::KEY_NONE;
      last_tick_key     <= aimsteer_pkg::KEY_NONE;
      direction_lock    <= aimsteer_pkg::DIR_UNKNOWN;
      direction_guess   <= aimsteer_pkg::DIR_UNKNOWN;
      agree_count       <= 3'd0;
      previous_coord    <= '0;
      previous_valid    <= 1'b0;
      player_was_active <= 1'b0;
      hold_start_time   <= '0;
      last_manual_time  <= '0;
      swing_latch       <= 1'b0;
    end else if (step) begin
      if (!ctl.engaged) begin
        held_key          <= aimsteer_pkg::KEY_NONE;
        last_tick_key     <= aimsteer_pkg::KEY_NONE;
        player_was_active <= ctl.pos_down || ctl.neg_down;
      end else begin
        held_key          <= held_key_next;
        last_tick_key     <= held_key_next;
        direction_lock    <= direction_lock_next;
        direction_guess   <= direction_guess_next;
        agree_count       <= agree_count_next;
        previous_coord    <= ANGLE_BITS'(cur);
        previous_valid    <= 1'b1;
        player_was_active <= active;
        hold_start_time   <= hold_start_time_next;
        last_manual_time  <= last_manual_time_next;
        swing_latch       <= swing_latch_next;
      end
    end
  end

  assign key       = held_key;
  assign direction = direction_lock;
  assign yielding  = swing_latch;

endmodule

/* hw/rtl/two_axis_bang_bang_aim_steer_top.sv */
// ----------------------------------------------------------------------------
// two_axis_bang_bang_aim_steer_top
// Path: an input transfer loads the input register; the tick then moves into
//   the axis state registers that also hold the result, held back while a
//   result waits on a stalled output.
// Throughput: one tick per cycle unless the output stalls; per-axis
//   compare/add logic sits between the input register and the state registers.
// Reset: synchronous, clears all axis state and the pipeline valids and
//   loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module two_axis_bang_bang_aim_steer_top #(
  parameter int ANGLE_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic signed [14:0]                         cur_az,
  input  logic signed [14:0]                         cur_el,
  input  logic signed [14:0]                         tgt_az,
  input  logic signed [14:0]                         tgt_el,
  input  logic                                       engage,
  input  logic                                       full_auto,
  input  logic                                       foreground,
  input  logic                                       az_pos_down,
  input  logic                                       az_neg_down,
  input  logic                                       el_pos_down,
  input  logic                                       el_neg_down,
  input  logic [31:0]                                now_ms,
  // output channel
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [1:0]                                 az_key,
  output logic [1:0]                                 el_key,
  output logic signed [1:0]                          az_direction,
  output logic signed [1:0]                          el_direction,
  output logic                                       az_yielding,
  output logic                                       el_yielding,
  // configuration
  input  logic                                       cfg_write,
  input  logic [aimsteer_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [aimsteer_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  aimsteer_pkg::cfg_t cfg;

  // Input register
  logic                 s1_valid;
  logic signed [14:0]   s1_cur_az, s1_cur_el, s1_tgt_az, s1_tgt_el;
  logic                 s1_engaged, s1_full_auto;
  logic                 s1_azp, s1_azn, s1_elp, s1_eln;
  logic [TIME_BITS-1:0] s1_now;

  logic                     advance;
  aimsteer_pkg::axis_ctl_t  az_ctl, el_ctl;

  // Flow control: hold the input while a result waits and the stage is full
  assign in_stall = s1_valid && out_valid && out_stall;
  assign advance  = s1_valid && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Capture the tick on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cur_az    <= cur_az;
      s1_cur_el    <= cur_el;
      s1_tgt_az    <= tgt_az;
      s1_tgt_el    <= tgt_el;
      s1_engaged   <= engage && foreground;
      s1_full_auto <= full_auto;
      s1_azp       <= az_pos_down;
      s1_azn       <= az_neg_down;
      s1_elp       <= el_pos_down;
      s1_eln       <= el_neg_down;
      s1_now       <= TIME_BITS'(now_ms);
    end
  end

  // Result valid: set on advance, drop once the result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband           <= aimsteer_pkg::DEADBAND_RST;
      cfg.hysteresis_margin  <= aimsteer_pkg::HYSTERESIS_RST;
      cfg.swing_hold_ms      <= aimsteer_pkg::SWING_HOLD_RST;
      cfg.release_grace_ms   <= aimsteer_pkg::RELEASE_GRACE_RST;
      cfg.calib_min_delta    <= aimsteer_pkg::CALIB_MIN_RST;
      cfg.calib_lock_samples <= aimsteer_pkg::CALIB_LOCK_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        aimsteer_pkg::CFG_DEADBAND:      cfg.deadband           <= cfg_data[13:0];
        aimsteer_pkg::CFG_HYSTERESIS:    cfg.hysteresis_margin  <= cfg_data[13:0];
        aimsteer_pkg::CFG_SWING_HOLD:    cfg.swing_hold_ms      <= cfg_data;
        aimsteer_pkg::CFG_RELEASE_GRACE: cfg.release_grace_ms   <= cfg_data;
        aimsteer_pkg::CFG_CALIB_MIN:     cfg.calib_min_delta    <= cfg_data[13:0];
        aimsteer_pkg::CFG_CALIB_LOCK:    cfg.calib_lock_samples <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Per-axis control
  always_comb begin
    az_ctl.engaged   = s1_engaged;
    az_ctl.full_auto = s1_full_auto;
    az_ctl.wraps     = 1'b1;
    az_ctl.pos_down  = s1_azp;
    az_ctl.neg_down  = s1_azn;
    el_ctl.engaged   = s1_engaged;
    el_ctl.full_auto = s1_full_auto;
    el_ctl.wraps     = 1'b0;
    el_ctl.pos_down  = s1_elp;
    el_ctl.neg_down  = s1_eln;
  end

  // Axis state registers double as the result register
  aimsteer_axis #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_az (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ctl       (az_ctl),
    .cfg       (cfg),
    .cur       (s1_cur_az),
    .tgt       (s1_tgt_az),
    .now       (s1_now),
    .key       (az_key),
    .direction (az_direction),
    .yielding  (az_yielding)
  );

  aimsteer_axis #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_el (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ctl       (el_ctl),
    .cfg       (cfg),
    .cur       (s1_cur_el),
    .tgt       (s1_tgt_el),
    .now       (s1_now),
    .key       (el_key),
    .direction (el_direction),
    .yielding  (el_yielding)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-axis bang-bang aim steering block. A short
// table of directed ticks covers the mode flags, key ownership, azimuth wrap,
// out-of-range angles, yield/grace timing and time rollover. Random phases
// follow, each under its own register setting and idling mix. A simple plant
// moves the angles according to the predicted keys so that calibration and
// the deadband logic are reached. Every result is compared with an in-order
// queue of predicted results.
// ----------------------------------------------------------------------------
module tb_top;

  // One input tick as driven on the ports
  typedef struct packed {
    logic [14:0] cur_az;
    logic [14:0] cur_el;
    logic [14:0] tgt_az;
    logic [14:0] tgt_el;
    logic        engage;
    logic        full_auto;
    logic        foreground;
    logic        azp;
    logic        azn;
    logic        elp;
    logic        eln;
    logic [31:0] now;
  } tick_t;

  // One result as seen on the ports
  typedef struct packed {
    logic [1:0] az_key;
    logic [1:0] el_key;
    logic [1:0] az_dir;
    logic [1:0] el_dir;
    logic       az_yield;
    logic       el_yield;
  } steer_out_t;

  // Per-axis steering state
  typedef struct packed {
    aimsteer_pkg::key_t held;
    logic [1:0]         lock;
    logic [1:0]         guess;
    logic [2:0]         agree;
    aimsteer_pkg::key_t last_key;
    logic [15:0]        prev;
    logic               prev_ok;
    logic               was_active;
    logic [31:0]        hold_start;
    logic [31:0]        last_manual;
    logic               latch;
  } axis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [14:0] cur_az = '0;
  logic signed [14:0] cur_el = '0;
  logic signed [14:0] tgt_az = '0;
  logic signed [14:0] tgt_el = '0;
  logic engage = 1'b0;
  logic full_auto = 1'b0;
  logic foreground = 1'b0;
  logic az_pos_down = 1'b0;
  logic az_neg_down = 1'b0;
  logic el_pos_down = 1'b0;
  logic el_neg_down = 1'b0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] az_key;
  logic [1:0] el_key;
  logic signed [1:0] az_direction;
  logic signed [1:0] el_direction;
  logic az_yielding;
  logic el_yielding;
  logic cfg_write = 1'b0;
  logic [aimsteer_pkg::CFG_IDX_BITS-1:0] cfg_index = aimsteer_pkg::CFG_DEADBAND;
  logic [aimsteer_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  aimsteer_pkg::cfg_t steer_cfg;
  axis_t      axes [2];
  steer_out_t steer_due [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  // Directed table
  tick_t      dir_tab [$];
  bit         dir_typed [$];
  steer_out_t dir_exp [$];

  // Plant used by the random part
  int          plant_az, plant_el, aim_az, aim_el, az_sgn, el_sgn;
  logic [31:0] clock_ms;
  int          man_left [2];
  logic [1:0]  man_keys [2];
  bit          auto_mode;

  two_axis_bang_bang_aim_steer_top u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bring an angle error into one half turn either way
  function automatic int wrap_turn(int d);
    while (d > aimsteer_pkg::HALF_TURN) d -= aimsteer_pkg::FULL_TURN;
    while (d < -aimsteer_pkg::HALF_TURN) d += aimsteer_pkg::FULL_TURN;
    return d;
  endfunction

  // A key belongs to the player only if this axis is not holding it
  function automatic bit player_on(axis_t a, bit p, bit n);
    return (p && a.held != aimsteer_pkg::KEY_POS) || (n && a.held != aimsteer_pkg::KEY_NEG);
  endfunction

  function automatic void step_axis(inout axis_t a, input int cur, input int err,
                                    input bit wraps, input bit fa, input bit p,
                                    input bit n, input logic [31:0] now);
    int delta, mag, dsign, psign, dir;
    bit act;
    aimsteer_pkg::key_t inc_k, dec_k;
    logic [31:0] dt;
    // learn key direction from the motion since the last tick
    if (a.lock == aimsteer_pkg::DIR_UNKNOWN && a.prev_ok &&
        a.last_key != aimsteer_pkg::KEY_NONE) begin
      delta = cur - int'($signed(a.prev));
      if (wraps) delta = wrap_turn(delta);
      mag = (delta < 0) ? -delta : delta;
      if (mag >= int'(steer_cfg.calib_min_delta)) begin
        dsign = (delta > 0) ? 1 : -1;
        psign = (a.last_key == aimsteer_pkg::KEY_POS) ? dsign : -dsign;
        if (a.agree == 3'd0 || psign == int'($signed(a.guess))) begin
          if (a.agree < aimsteer_pkg::AGREE_MAX) a.agree = a.agree + 3'd1;
        end else begin
          a.agree = 3'd1;
        end
        a.guess = 2'(psign);
        if (a.agree >= steer_cfg.calib_lock_samples) a.lock = a.guess;
      end
    end
    a.prev = 16'(cur);
    a.prev_ok = 1'b1;
    // track manual holds and the yield latch
    act = player_on(a, p, n);
    if (act && !a.was_active) a.hold_start = now;
    if (act) begin
      a.last_manual = now;
      dt = now - a.hold_start;
      if (dt >= 32'(steer_cfg.swing_hold_ms)) a.latch = 1'b1;
    end else begin
      dt = now - a.last_manual;
      if (a.latch && dt >= 32'(steer_cfg.release_grace_ms)) a.latch = 1'b0;
    end
    a.was_active = act;
    if (!fa && a.latch) begin
      a.held = aimsteer_pkg::KEY_NONE;
      a.last_key = aimsteer_pkg::KEY_NONE;
      return;
    end
    // bang-bang drive with deadband and engage hysteresis
    inc_k = (a.lock == aimsteer_pkg::DIR_NEG) ? aimsteer_pkg::KEY_NEG : aimsteer_pkg::KEY_POS;
    dec_k = (a.lock == aimsteer_pkg::DIR_NEG) ? aimsteer_pkg::KEY_POS : aimsteer_pkg::KEY_NEG;
    dir = 0;
    if (err > int'(steer_cfg.deadband)) dir = -1;
    else if (err < -int'(steer_cfg.deadband)) dir = 1;
    mag = (err < 0) ? -err : err;
    if (a.held == aimsteer_pkg::KEY_NONE && dir != 0 &&
        mag < int'(steer_cfg.deadband) + int'(steer_cfg.hysteresis_margin))
      dir = 0;
    a.held = (dir > 0) ? inc_k : ((dir < 0) ? dec_k : aimsteer_pkg::KEY_NONE);
    a.last_key = a.held;
  endfunction

  function automatic steer_out_t steer_tick(tick_t t);
    steer_out_t r;
    int caz, cel;
    caz = int'($signed(t.cur_az));
    cel = int'($signed(t.cur_el));
    if (!t.engage || !t.foreground) begin
      // release everything, remember raw key state
      axes[0].held = aimsteer_pkg::KEY_NONE;
      axes[1].held = aimsteer_pkg::KEY_NONE;
      axes[0].last_key = aimsteer_pkg::KEY_NONE;
      axes[1].last_key = aimsteer_pkg::KEY_NONE;
      axes[0].was_active = player_on(axes[0], t.azp, t.azn);
      axes[1].was_active = player_on(axes[1], t.elp, t.eln);
    end else begin
      step_axis(axes[0], caz, wrap_turn(caz - int'($signed(t.tgt_az))), 1'b1,
                t.full_auto, t.azp, t.azn, t.now);
      step_axis(axes[1], cel, cel - int'($signed(t.tgt_el)), 1'b0,
                t.full_auto, t.elp, t.eln, t.now);
    end
    r.az_key = axes[0].held;
    r.el_key = axes[1].held;
    r.az_dir = axes[0].lock;
    r.el_dir = axes[1].lock;
    r.az_yield = axes[0].latch;
    r.el_yield = axes[1].latch;
    return r;
  endfunction

  function automatic tick_t mk_tick(int caz, int cel, int taz, int tel, bit eng,
                                    bit fa, bit fg, bit azp, bit azn, bit elp,
                                    bit eln, logic [31:0] now);
    tick_t t;
    t.cur_az = 15'(caz);
    t.cur_el = 15'(cel);
    t.tgt_az = 15'(taz);
    t.tgt_el = 15'(tel);
    t.engage = eng;
    t.full_auto = fa;
    t.foreground = fg;
    t.azp = azp;
    t.azn = azn;
    t.elp = elp;
    t.eln = eln;
    t.now = now;
    return t;
  endfunction

  function automatic void add_row(tick_t t, bit typed, steer_out_t e);
    dir_tab.push_back(t);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endfunction

  function automatic void check_field(string name, logic signed [2:0] want,
                                      logic signed [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Drive one tick, wait for its transfer, then queue its result
  task automatic send_tick(input tick_t t, input bit typed, input steer_out_t e);
    steer_out_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_az <= t.cur_az;
    cur_el <= t.cur_el;
    tgt_az <= t.tgt_az;
    tgt_el <= t.tgt_el;
    engage <= t.engage;
    full_auto <= t.full_auto;
    foreground <= t.foreground;
    az_pos_down <= t.azp;
    az_neg_down <= t.azn;
    el_pos_down <= t.elp;
    el_neg_down <= t.eln;
    now_ms <= t.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = steer_tick(t);
    steer_due.push_back(typed ? e : p);
  endtask

  // Stop sending and wait until every queued result has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (steer_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aimsteer_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [aimsteer_pkg::CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      aimsteer_pkg::CFG_DEADBAND:      steer_cfg.deadband = val[13:0];
      aimsteer_pkg::CFG_HYSTERESIS:    steer_cfg.hysteresis_margin = val[13:0];
      aimsteer_pkg::CFG_SWING_HOLD:    steer_cfg.swing_hold_ms = val;
      aimsteer_pkg::CFG_RELEASE_GRACE: steer_cfg.release_grace_ms = val;
      aimsteer_pkg::CFG_CALIB_MIN:     steer_cfg.calib_min_delta = val[13:0];
      aimsteer_pkg::CFG_CALIB_LOCK:    steer_cfg.calib_lock_samples = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_cfg(input logic [15:0] db, input logic [15:0] hy,
                             input logic [15:0] sw, input logic [15:0] rg,
                             input logic [15:0] cm, input logic [15:0] cl);
    write_reg(aimsteer_pkg::CFG_DEADBAND, db);
    write_reg(aimsteer_pkg::CFG_HYSTERESIS, hy);
    write_reg(aimsteer_pkg::CFG_SWING_HOLD, sw);
    write_reg(aimsteer_pkg::CFG_RELEASE_GRACE, rg);
    write_reg(aimsteer_pkg::CFG_CALIB_MIN, cm);
    write_reg(aimsteer_pkg::CFG_CALIB_LOCK, cl);
    cfg_write <= 1'b0;
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    steer_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (steer_due.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatches++;
      end else begin
        want = steer_due.pop_front();
        check_field("az_key", want.az_key, az_key);
        check_field("el_key", want.el_key, el_key);
        check_field("az_direction", $signed(want.az_dir), az_direction);
        check_field("el_direction", $signed(want.el_dir), el_direction);
        check_field("az_yielding", want.az_yield, az_yielding);
        check_field("el_yielding", want.el_yield, el_yielding);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tick_t t;
    steer_out_t zero_out, lead_out;
    int ph, n, k, r, step;

    steer_cfg.deadband = aimsteer_pkg::DEADBAND_RST;
    steer_cfg.hysteresis_margin = aimsteer_pkg::HYSTERESIS_RST;
    steer_cfg.swing_hold_ms = aimsteer_pkg::SWING_HOLD_RST;
    steer_cfg.release_grace_ms = aimsteer_pkg::RELEASE_GRACE_RST;
    steer_cfg.calib_min_delta = aimsteer_pkg::CALIB_MIN_RST;
    steer_cfg.calib_lock_samples = aimsteer_pkg::CALIB_LOCK_RST;
    axes[0] = '0;
    axes[1] = '0;
    zero_out = '0;
    lead_out = '0;
    lead_out.az_key = aimsteer_pkg::KEY_POS;
    lead_out.el_key = aimsteer_pkg::KEY_NEG;

    // Directed ticks under the reset setting
    add_row(mk_tick(0, 0, 5000, 5000, 0, 0, 1, 0, 0, 0, 0, 0), 1, zero_out);
    add_row(mk_tick(0, 0, 5000, -5000, 1, 0, 0, 0, 0, 0, 0, 10), 1, zero_out);
    add_row(mk_tick(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 20), 1, zero_out);
    // error past the deadband but short of the engage margin
    add_row(mk_tick(0, 0, 300, -319, 1, 0, 1, 0, 0, 0, 0, 30), 1, zero_out);
    add_row(mk_tick(0, 0, 1000, -1000, 1, 0, 1, 0, 0, 0, 0, 40), 1, lead_out);
    // motion under own keys: calibration samples
    add_row(mk_tick(100, -100, 1000, -1000, 1, 0, 1, 1, 0, 0, 1, 50), 0, zero_out);
    add_row(mk_tick(200, -200, 1000, -1000, 1, 0, 1, 1, 0, 0, 1, 60), 0, zero_out);
    // azimuth error across the half-turn seam
    add_row(mk_tick(11000, 0, -11000, 0, 1, 0, 1, 1, 0, 0, 1, 70), 0, zero_out);
    add_row(mk_tick(-16384, 16383, 16383, -16384, 1, 0, 1, 0, 0, 0, 0, 80), 0, zero_out);
    // manual hold, yield, release grace
    add_row(mk_tick(0, 0, 2000, 2000, 1, 0, 1, 0, 1, 0, 0, 100), 0, zero_out);
    add_row(mk_tick(0, 0, 2000, 2000, 1, 0, 1, 0, 1, 0, 0, 500), 0, zero_out);
    add_row(mk_tick(0, 0, 2000, 2000, 1, 0, 1, 0, 0, 0, 0, 600), 0, zero_out);
    add_row(mk_tick(0, 0, 2000, 2000, 1, 0, 1, 0, 0, 0, 0, 900), 0, zero_out);
    // full auto keeps driving while latched
    add_row(mk_tick(0, 0, 2000, 2000, 1, 1, 1, 0, 0, 1, 1, 1000), 0, zero_out);
    add_row(mk_tick(0, 0, 2000, 2000, 1, 1, 1, 0, 0, 1, 1, 2000), 0, zero_out);
    add_row(mk_tick(0, 0, 2000, 2000, 0, 1, 1, 1, 1, 1, 1, 2100), 0, zero_out);
    // hold timing across time rollover
    add_row(mk_tick(0, 0, 3000, 3000, 1, 0, 1, 1, 1, 0, 0, 32'hFFFF_FF00), 0, zero_out);
    add_row(mk_tick(0, 0, 3000, 3000, 1, 0, 1, 1, 1, 0, 0, 32'h0000_0100), 0, zero_out);
    add_row(mk_tick(16383, 16383, -16384, -16384, 1, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF),
            0, zero_out);
    add_row(mk_tick(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 32'h0000_1000), 0, zero_out);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_tab.size(); i++) send_tick(dir_tab[i], dir_typed[i], dir_exp[i]);
    drain;

    // Random phases
    plant_az = 0;
    plant_el = 0;
    aim_az = 4000;
    aim_el = -3000;
    az_sgn = ($urandom_range(1) != 0) ? 1 : -1;
    el_sgn = ($urandom_range(1) != 0) ? 1 : -1;
    clock_ms = $urandom;
    man_left[0] = 0;
    man_left[1] = 0;
    man_keys[0] = '0;
    man_keys[1] = '0;
    auto_mode = 1'b0;

    for (ph = 0; ph < 8; ph++) begin
      repeat (2) @(posedge clk);
      case (ph)
        0: program_cfg(aimsteer_pkg::DEADBAND_RST, aimsteer_pkg::HYSTERESIS_RST,
                       aimsteer_pkg::SWING_HOLD_RST, aimsteer_pkg::RELEASE_GRACE_RST,
                       aimsteer_pkg::CALIB_MIN_RST, aimsteer_pkg::CALIB_LOCK_RST);
        1: program_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
        2: program_cfg(16'd11520, 16'd11520, 16'hFFFF, 16'hFFFF, 16'd11520, 16'd7);
        // bits above the register widths, lock count of zero
        3: program_cfg(16'hC0C8, 16'hC040, 16'd100, 16'd50, 16'hC010, 16'hFFF8);
        default: program_cfg(16'($urandom_range(600)), 16'($urandom_range(600)),
                             16'($urandom_range(800)), 16'($urandom_range(800)),
                             16'($urandom_range(150)), 16'($urandom_range(7)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase

      for (n = 0; n < 220; n++) begin
        if ($urandom_range(99) < 10) begin
          // noise: any field value
          t.cur_az = 15'($urandom);
          t.cur_el = 15'($urandom);
          t.tgt_az = 15'($urandom);
          t.tgt_el = 15'($urandom);
          t.engage = $urandom_range(1);
          t.full_auto = $urandom_range(1);
          t.foreground = $urandom_range(1);
          t.azp = $urandom_range(1);
          t.azn = $urandom_range(1);
          t.elp = $urandom_range(1);
          t.eln = $urandom_range(1);
          t.now = $urandom;
        end else begin
          // tracking tick: own keys show up as pressed, player presses on top
          r = $urandom_range(99);
          clock_ms = clock_ms + ((r < 2) ? $urandom : $urandom_range(150));
          if ($urandom_range(99) < 4) begin
            aim_az = int'($urandom_range(23040)) - aimsteer_pkg::HALF_TURN;
            aim_el = int'($urandom_range(23040)) - aimsteer_pkg::HALF_TURN;
          end else if ($urandom_range(99) < 4) begin
            aim_az = plant_az + int'($urandom_range(800)) - 400;
            aim_el = plant_el + int'($urandom_range(800)) - 400;
          end
          for (k = 0; k < 2; k++) begin
            if (man_left[k] == 0 && $urandom_range(99) < 3) begin
              man_left[k] = $urandom_range(40, 1);
              man_keys[k] = 2'($urandom_range(3, 1));
            end
          end
          if ($urandom_range(99) < 2) auto_mode = !auto_mode;
          t.cur_az = 15'(plant_az);
          t.cur_el = 15'(plant_el);
          t.tgt_az = 15'(aim_az);
          t.tgt_el = 15'(aim_el);
          t.engage = ($urandom_range(99) >= 3);
          t.foreground = ($urandom_range(99) >= 3);
          t.full_auto = auto_mode;
          t.azp = (axes[0].held == aimsteer_pkg::KEY_POS) ||
                  (man_left[0] != 0 && man_keys[0][0]);
          t.azn = (axes[0].held == aimsteer_pkg::KEY_NEG) ||
                  (man_left[0] != 0 && man_keys[0][1]);
          t.elp = (axes[1].held == aimsteer_pkg::KEY_POS) ||
                  (man_left[1] != 0 && man_keys[1][0]);
          t.eln = (axes[1].held == aimsteer_pkg::KEY_NEG) ||
                  (man_left[1] != 0 && man_keys[1][1]);
          t.now = clock_ms;
          for (k = 0; k < 2; k++) begin
            if (man_left[k] != 0) man_left[k]--;
          end
        end
        send_tick(t, 1'b0, zero_out);

        // move the plant under the keys now held
        step = $urandom_range(300);
        if (axes[0].held == aimsteer_pkg::KEY_POS) plant_az += az_sgn * step;
        else if (axes[0].held == aimsteer_pkg::KEY_NEG) plant_az -= az_sgn * step;
        if (plant_az > aimsteer_pkg::HALF_TURN) plant_az -= aimsteer_pkg::FULL_TURN;
        else if (plant_az < -aimsteer_pkg::HALF_TURN) plant_az += aimsteer_pkg::FULL_TURN;
        if (axes[1].held == aimsteer_pkg::KEY_POS) plant_el += el_sgn * step;
        else if (axes[1].held == aimsteer_pkg::KEY_NEG) plant_el -= el_sgn * step;
        if (plant_el > aimsteer_pkg::HALF_TURN) plant_el = aimsteer_pkg::HALF_TURN;
        else if (plant_el < -aimsteer_pkg::HALF_TURN) plant_el = -aimsteer_pkg::HALF_TURN;
      end
      drain;
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/aimsteer_pkg.sv
hw/rtl/aimsteer_axis.sv
hw/rtl/two_axis_bang_bang_aim_steer_top.sv
bench/tb_top.sv
